>>> rtl/hel_pkg.sv
// Shared types, constants and helpers for the hypergraph edge-list engine.
`timescale 1ns / 1ps
package hel_pkg;
    localparam int VERTEX_W     = 10;
    localparam int EDGE_W       = 9;
    localparam int DEG_W        = 8;
    localparam int LINK_W       = EDGE_W + 1;
    localparam int VERTEX_COUNT = 1 << VERTEX_W;
    localparam int EDGE_COUNT   = 1 << EDGE_W;
    localparam int EWORD_W      = 6 * VERTEX_W;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(EDGE_COUNT);
    localparam logic [DEG_W-1:0]  DEG_MAX = '1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_VERT  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // One vertex entry: head of the edge list and the degree.
    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [DEG_W-1:0]  deg;
    } vent_t;

    // Write port of the vertex store.
    typedef struct packed {
        logic                en;
        logic [VERTEX_W-1:0] addr;
        vent_t               data;
    } vwr_t;

    // Edge word: three vertices in the low half, three next links above.
    function automatic logic [VERTEX_W-1:0] ew_vert(input logic [EWORD_W-1:0] w,
                                                   input logic [1:0] k);
        ew_vert = w[VERTEX_W*k +: VERTEX_W];
    endfunction

    function automatic logic [LINK_W-1:0] ew_link(input logic [EWORD_W-1:0] w,
                                                 input logic [1:0] k);
        ew_link = w[3*VERTEX_W + LINK_W*k +: LINK_W];
    endfunction
endpackage

>>> rtl/hypergraph_edge_list_engine_unit.sv
// Top level: 3-uniform hypergraph kept as per-vertex linked edge lists.
// Add: reads and updates each of the three vertex entries, then stores the edge
// word; a rejected request goes straight to the result. Remove: reads the edge
// word, then walks the three vertex lists and unlinks the edge from each. One
// transaction at a time; the next can be taken once the result is registered.
// After reset a sweep clears all 1024 vertex store entries; input stalls meanwhile.
`timescale 1ns / 1ps
module hypergraph_edge_list_engine_unit import hel_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [VERTEX_W-1:0] vertex_a,
    input  logic [VERTEX_W-1:0] vertex_b,
    input  logic [VERTEX_W-1:0] vertex_c,
    input  logic [EDGE_W-1:0]   edge_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [EDGE_W-1:0]   edge_number,
    output logic [VERTEX_W-1:0] out_vertex_a,
    output logic [VERTEX_W-1:0] out_vertex_b,
    output logic [VERTEX_W-1:0] out_vertex_c,
    output logic [DEG_W-1:0]    degree_a,
    output logic [DEG_W-1:0]    degree_b,
    output logic [DEG_W-1:0]    degree_c,
    output logic [LINK_W-1:0]   edge_total
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD_RD   = 4'd1;
    localparam logic [3:0] S_ADD_WR   = 4'd2;
    localparam logic [3:0] S_ADD_EDGE = 4'd3;
    localparam logic [3:0] S_RM_RDE   = 4'd4;
    localparam logic [3:0] S_RM_GETE  = 4'd5;
    localparam logic [3:0] S_RM_RDV   = 4'd6;
    localparam logic [3:0] S_RM_GETV  = 4'd7;
    localparam logic [3:0] S_WALK     = 4'd8;
    localparam logic [3:0] S_WALK_GET = 4'd9;
    localparam logic [3:0] S_UPD      = 4'd10;
    localparam logic [3:0] S_UPD_WR   = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          idx_reg;
    logic [LINK_W-1:0]   edges_added_reg;
    logic                out_valid_reg;

    logic                act_reg;
    logic [1:0]          status_reg;
    logic [EDGE_W-1:0]   e_reg;
    logic [VERTEX_W-1:0] v_reg     [3];
    logic [LINK_W-1:0]   links_reg [3];
    logic [LINK_W-1:0]   head_reg  [3];
    logic [LINK_W-1:0]   prev_reg  [3];
    logic [1:0]          pslot_reg [3];
    logic [DEG_W-1:0]    deg_reg   [3];
    logic [LINK_W-1:0]   cur_reg, before_reg, steps_reg;
    logic [1:0]          slot_reg;

    logic [1:0]          out_status_reg;
    logic [EDGE_W-1:0]   out_edge_reg;
    logic [VERTEX_W-1:0] out_v_reg   [3];
    logic [DEG_W-1:0]    out_deg_reg [3];
    logic [LINK_W-1:0]   out_total_reg;

    logic [EWORD_W-1:0]  emem [EDGE_COUNT];
    logic [EWORD_W-1:0]  e_rdata_reg;
    logic [EDGE_W-1:0]   e_raddr, e_waddr;
    logic [EWORD_W-1:0]  e_wdata;
    logic                e_we;

    logic [VERTEX_W-1:0] v_raddr;
    vent_t               v_rdata;
    vwr_t                v_wr;
    logic                vs_ready;

    logic                in_accept, out_free, last_idx;
    logic                found, walk_go;
    logic                verts_bad;
    logic [DEG_W-1:0]    deg_up, deg_down;
    logic [1:0]          walk_slot;

    hel_vstore u_vstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (v_raddr),
        .rd_data (v_rdata),
        .wr      (v_wr),
        .ready   (vs_ready)
    );

    assign in_stall  = (state_reg != S_IDLE) || !vs_ready;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_idx  = (idx_reg == 2'd2);

    // Request checks at accept time.
    assign verts_bad = (vertex_a == vertex_b) || (vertex_a == vertex_c) ||
                       (vertex_b == vertex_c);

    // Walk control and degree arithmetic.
    assign found    = (cur_reg == {1'b0, e_reg});
    assign walk_go  = (cur_reg < NO_LINK) && (steps_reg < edges_added_reg);
    assign deg_up   = (v_rdata.deg == DEG_MAX) ? DEG_MAX : v_rdata.deg + 1'b1;
    assign deg_down = (deg_reg[idx_reg] == '0) ? '0 : deg_reg[idx_reg] - 1'b1;
    assign walk_slot = (ew_vert(e_rdata_reg, 2'd0) == v_reg[idx_reg]) ? 2'd0 :
                       (ew_vert(e_rdata_reg, 2'd1) == v_reg[idx_reg]) ? 2'd1 : 2'd2;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACT_ADD)
                    begin
                        state_next = (edges_added_reg >= NO_LINK || verts_bad) ?
                                     S_DONE : S_ADD_RD;
                    end
                    else
                    begin
                        state_next = ({1'b0, edge_index} >= edges_added_reg) ?
                                     S_DONE : S_RM_RDE;
                    end
                end
            end
            S_ADD_RD:   state_next = S_ADD_WR;
            S_ADD_WR:   state_next = last_idx ? S_ADD_EDGE : S_ADD_RD;
            S_ADD_EDGE: state_next = S_DONE;
            S_RM_RDE:   state_next = S_RM_GETE;
            S_RM_GETE:  state_next = S_RM_RDV;
            S_RM_RDV:   state_next = S_RM_GETV;
            S_RM_GETV:  state_next = S_WALK;
            S_WALK:
            begin
                if (found)
                begin
                    state_next = last_idx ? S_UPD : S_RM_RDV;
                end
                else if (walk_go)
                begin
                    state_next = S_WALK_GET;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK_GET: state_next = S_WALK;
            S_UPD:
            begin
                if (prev_reg[idx_reg] != NO_LINK)
                begin
                    state_next = S_UPD_WR;
                end
                else
                begin
                    state_next = last_idx ? S_DONE : S_UPD;
                end
            end
            S_UPD_WR:   state_next = last_idx ? S_DONE : S_UPD;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Memory port addresses and write data.
    always_comb
    begin
        v_raddr = v_reg[idx_reg];
        e_raddr = e_reg;
        e_we    = 1'b0;
        e_waddr = e_reg;
        e_wdata = {links_reg[2], links_reg[1], links_reg[0], v_reg[2], v_reg[1], v_reg[0]};
        v_wr    = '0;
        case (state_reg)
            S_ADD_WR:
            begin
                v_wr.en   = 1'b1;
                v_wr.addr = v_reg[idx_reg];
                v_wr.data = '{head: {1'b0, e_reg}, deg: deg_up};
            end
            S_ADD_EDGE:
            begin
                e_we = 1'b1;
            end
            S_WALK:
            begin
                e_raddr = cur_reg[EDGE_W-1:0];
            end
            S_UPD:
            begin
                e_raddr   = prev_reg[idx_reg][EDGE_W-1:0];
                v_wr.en   = 1'b1;
                v_wr.addr = v_reg[idx_reg];
                v_wr.data.deg  = deg_down;
                v_wr.data.head = (prev_reg[idx_reg] == NO_LINK) ?
                                 links_reg[idx_reg] : head_reg[idx_reg];
            end
            S_UPD_WR:
            begin
                e_we    = 1'b1;
                e_waddr = prev_reg[idx_reg][EDGE_W-1:0];
                e_wdata = e_rdata_reg;
                e_wdata[3*VERTEX_W + LINK_W*pslot_reg[idx_reg] +: LINK_W] =
                    links_reg[idx_reg];
            end
            default:
            begin
            end
        endcase
    end

    // Edge memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            emem[e_waddr] <= e_wdata;
        end
        e_rdata_reg <= emem[e_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            edges_added_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                end
                S_ADD_WR, S_UPD_WR:
                begin
                    idx_reg <= last_idx ? 2'd0 : idx_reg + 1'b1;
                end
                S_WALK:
                begin
                    if (found)
                    begin
                        idx_reg <= last_idx ? 2'd0 : idx_reg + 1'b1;
                    end
                end
                S_UPD:
                begin
                    if (prev_reg[idx_reg] == NO_LINK)
                    begin
                        idx_reg <= last_idx ? 2'd0 : idx_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (state_reg == S_ADD_EDGE)
            begin
                edges_added_reg <= edges_added_reg + 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the transaction in flight.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                act_reg    <= action;
                e_reg      <= (action == ACT_ADD) ? edges_added_reg[EDGE_W-1:0] : edge_index;
                v_reg[0]   <= vertex_a;
                v_reg[1]   <= vertex_b;
                v_reg[2]   <= vertex_c;
                if (action == ACT_ADD)
                begin
                    status_reg <= (edges_added_reg >= NO_LINK) ? ST_FULL :
                                  verts_bad ? ST_BAD_VERT : ST_OK;
                end
                else
                begin
                    status_reg <= ({1'b0, edge_index} >= edges_added_reg) ?
                                  ST_NOT_FOUND : ST_OK;
                end
            end
            S_ADD_WR:
            begin
                links_reg[idx_reg] <= v_rdata.head;
                deg_reg[idx_reg]   <= deg_up;
            end
            S_RM_GETE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v_reg[k]     <= ew_vert(e_rdata_reg, 2'(k));
                    links_reg[k] <= ew_link(e_rdata_reg, 2'(k));
                end
            end
            S_RM_GETV:
            begin
                head_reg[idx_reg] <= v_rdata.head;
                deg_reg[idx_reg]  <= v_rdata.deg;
                cur_reg           <= v_rdata.head;
                before_reg        <= NO_LINK;
                slot_reg          <= 2'd0;
                steps_reg         <= '0;
            end
            S_WALK:
            begin
                if (found)
                begin
                    prev_reg[idx_reg]  <= before_reg;
                    pslot_reg[idx_reg] <= slot_reg;
                end
                else if (!walk_go)
                begin
                    status_reg <= ST_NOT_FOUND;
                end
            end
            S_WALK_GET:
            begin
                slot_reg   <= walk_slot;
                before_reg <= cur_reg;
                cur_reg    <= ew_link(e_rdata_reg, walk_slot);
                steps_reg  <= steps_reg + 1'b1;
            end
            S_UPD:
            begin
                deg_reg[idx_reg] <= deg_down;
            end
            default:
            begin
            end
        endcase
    end

    // Result register; an error result carries zeros but for the echo fields.
    // The edge count is captured with the result so it holds while stalled.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg <= status_reg;
            out_total_reg  <= edges_added_reg;
            if (status_reg == ST_OK)
            begin
                out_edge_reg <= e_reg;
                for (int k = 0; k < 3; k++)
                begin
                    out_v_reg[k]   <= v_reg[k];
                    out_deg_reg[k] <= deg_reg[k];
                end
            end
            else
            begin
                out_edge_reg <= (act_reg == ACT_REMOVE) ? e_reg : '0;
                for (int k = 0; k < 3; k++)
                begin
                    out_v_reg[k]   <= '0;
                    out_deg_reg[k] <= '0;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign edge_number  = out_edge_reg;
    assign out_vertex_a = out_v_reg[0];
    assign out_vertex_b = out_v_reg[1];
    assign out_vertex_c = out_v_reg[2];
    assign degree_a     = out_deg_reg[0];
    assign degree_b     = out_deg_reg[1];
    assign degree_c     = out_deg_reg[2];
    assign edge_total   = out_total_reg;

    // The edge count never passes the table size.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_added_reg <= NO_LINK)
        else $error("edge count beyond table size");

    // A list walk never takes more steps than there are edges.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> steps_reg <= edges_added_reg)
        else $error("list walk overran edge count");

    // No transaction is taken while the vertex store is still being cleared.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vs_ready |-> in_stall)
        else $error("input accepted during clearing sweep");

    // An add can only be committed while the table has room.
    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_EDGE |-> edges_added_reg < NO_LINK)
        else $error("edge stored into a full table");
endmodule

>>> rtl/hel_vstore.sv
// Vertex store: list heads and degrees, with a clearing sweep after reset.
`timescale 1ns / 1ps
module hel_vstore import hel_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [VERTEX_W-1:0] rd_addr,
    output vent_t               rd_data,
    input  vwr_t                wr,
    output logic                ready
);
    logic [VERTEX_W:0] clr_reg;
    vent_t             mem [VERTEX_COUNT];
    vent_t             rd_data_reg;

    assign ready   = clr_reg[VERTEX_W];
    assign rd_data = rd_data_reg;

    // Sweep counter walks every entry once after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (!ready)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // The array itself; the sweep has priority over the normal write port.
    always_ff @(posedge clk)
    begin
        if (!ready)
        begin
            mem[clr_reg[VERTEX_W-1:0]] <= '{head: NO_LINK, deg: '0};
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end
endmodule
